// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// String literal unescaper package
// Result kinds, fault codes and the small byte decoders of the unescaper.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Result kinds, carried on tuser of the result stream.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Fault codes.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_STRAY_CONT    = 3'd1;
    localparam logic [2:0] ERR_LEAD_TOO_LONG = 3'd2;
    localparam logic [2:0] ERR_MISSING_CONT  = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd4;
    localparam logic [2:0] ERR_NOT_HEX       = 3'd5;
    localparam logic [2:0] ERR_RANGE         = 3'd6;
    localparam logic [2:0] ERR_SURROGATE     = 3'd7;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_U    = 8'h75;

    localparam logic [23:0] UNICODE_MAX   = 24'h10FFFF;
    localparam logic [23:0] HEX_BYTE_MAX  = 24'h00007F;
    localparam logic [23:0] SURR_LOW      = 24'h00D800;
    localparam logic [23:0] SURR_HIGH     = 24'h00DFFF;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } esc_char_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.value = 4'(b - 8'h37);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic esc_char_t esc_decode(input logic [7:0] b);
        esc_char_t r;
        r.ok = 1'b1;
        case (b)
            8'h27:   r.value = 8'h27;
            8'h22:   r.value = 8'h22;
            8'h5C:   r.value = 8'h5C;
            8'h24:   r.value = 8'h24;
            8'h30:   r.value = 8'h00;
            8'h61:   r.value = 8'h07;
            8'h62:   r.value = 8'h08;
            8'h66:   r.value = 8'h0C;
            8'h6E:   r.value = 8'h0A;
            8'h72:   r.value = 8'h0D;
            8'h74:   r.value = 8'h09;
            8'h76:   r.value = 8'h0B;
            default:
            begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/string_literal_unescaper_core.sv =====
// ----------------------------------------------------------------------------
// String literal unescaper core
// Decodes escapes and checks UTF-8 structure of a quoted literal, byte by byte.
// ----------------------------------------------------------------------------
// Flow: an accepted item sits in the input register and is decoded into the
// result group register once that is free; its results leave from there.
// Throughput: one item per cycle while m_tready is high; an item causing n
// results holds the group register until all n are taken, one per cycle.
// Reset: rst_n clears all control state; the block then waits for a begin item.
module string_literal_unescaper_core
    import sle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] begin_req
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last result of the item
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TEXT,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_UTF8,
        MODE_ENDED
    } mode_t;

    // Configuration registers
    logic [7:0]  stop_byte_reg;
    logic        skip_opening_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_begin_reg;
    logic [7:0]  in_byte_reg;

    // Decoder state
    mode_t       mode_reg, mode_next;
    logic [1:0]  cont_left_reg, cont_left_next;
    logic [23:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [23:0] hex_value_reg, hex_value_next;
    logic [2:0]  hex_left_reg, hex_left_next;
    logic        hex_unicode_reg, hex_unicode_next;

    // Result group register
    logic        grp_valid_reg;
    logic [7:0]  grp_bytes_reg [4];
    logic [1:0]  grp_last_idx_reg;
    logic [1:0]  grp_idx_reg;
    logic [1:0]  grp_kind_reg;
    logic [2:0]  grp_code_reg;

    // Decode results
    logic [2:0]  res_cnt;
    logic [7:0]  res_bytes [4];
    logic [1:0]  res_kind;
    logic [2:0]  res_code;

    logic        out_take;
    logic        grp_done;
    logic        grp_free;
    logic        proc;
    logic        in_take;
    logic        cfg_write;

    logic [7:0]  b;
    logic        run_en;
    mode_t       work_mode;
    hex_digit_t  hx;
    esc_char_t   es;
    logic [23:0] nv;
    logic [2:0]  hex_left_dec;
    logic        flt;
    logic [2:0]  flt_code;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_take = m_tvalid && m_tready;
    assign grp_done = out_take && (grp_idx_reg == grp_last_idx_reg);
    assign grp_free = !grp_valid_reg || grp_done;
    assign proc     = in_valid_reg && grp_free;
    assign s_tready = !in_valid_reg || proc;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = {5'd0, grp_code_reg, grp_bytes_reg[grp_idx_reg]};
    assign m_tuser  = grp_kind_reg;
    assign m_tlast  = (grp_idx_reg == grp_last_idx_reg);

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2])
        begin
            prdata = {31'd0, skip_opening_reg};
        end
        else
        begin
            prdata = {24'd0, stop_byte_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_byte_reg    <= 8'd34;
            skip_opening_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                skip_opening_reg <= pwdata[0];
            end
            else
            begin
                stop_byte_reg <= pwdata[7:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Decode of the item held in the input register
    // ------------------------------------------------------------------
    always_comb
    begin
        b            = in_byte_reg;
        hx           = hex_decode(b);
        es           = esc_decode(b);
        nv           = {hex_value_reg[19:0], hx.value};
        hex_left_dec = hex_left_reg - 3'd1;
        run_en       = !(in_begin_reg && skip_opening_reg);
        work_mode    = in_begin_reg ? MODE_TEXT : mode_reg;
        flt          = 1'b0;
        flt_code     = ERR_NONE;

        // A begin item clears the state and opens a new literal.
        if (in_begin_reg)
        begin
            mode_next        = MODE_TEXT;
            cont_left_next   = 2'd0;
            held_bytes_next  = 24'd0;
            held_count_next  = 2'd0;
            hex_value_next   = 24'd0;
            hex_left_next    = 3'd0;
            hex_unicode_next = 1'b0;
        end
        else
        begin
            mode_next        = mode_reg;
            cont_left_next   = cont_left_reg;
            held_bytes_next  = held_bytes_reg;
            held_count_next  = held_count_reg;
            hex_value_next   = hex_value_reg;
            hex_left_next    = hex_left_reg;
            hex_unicode_next = hex_unicode_reg;
        end

        res_cnt  = 3'd0;
        res_kind = KIND_DATA;
        res_code = ERR_NONE;
        for (int i = 0; i < 4; i++)
        begin
            res_bytes[i] = 8'd0;
        end

        if (run_en)
        begin
            case (work_mode)
                MODE_TEXT:
                begin
                    if (b == stop_byte_reg)
                    begin
                        mode_next = MODE_ENDED;
                        res_cnt   = 3'd1;
                        res_kind  = KIND_DONE;
                    end
                    else if (b == BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (!b[7])
                    begin
                        res_cnt      = 3'd1;
                        res_bytes[0] = b;
                    end
                    else if (b[7:6] == 2'b10)
                    begin
                        flt      = 1'b1;
                        flt_code = ERR_STRAY_CONT;
                    end
                    else if (b[7:3] == 5'b11111)
                    begin
                        flt      = 1'b1;
                        flt_code = ERR_LEAD_TOO_LONG;
                    end
                    else
                    begin
                        if (b[7:5] == 3'b110)
                        begin
                            cont_left_next = 2'd1;
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            cont_left_next = 2'd2;
                        end
                        else
                        begin
                            cont_left_next = 2'd3;
                        end
                        held_bytes_next = {16'd0, b};
                        held_count_next = 2'd1;
                        mode_next       = MODE_UTF8;
                    end
                end
                MODE_UTF8:
                begin
                    if (b[7:6] != 2'b10)
                    begin
                        flt      = 1'b1;
                        flt_code = ERR_MISSING_CONT;
                    end
                    else if (cont_left_reg <= 2'd1)
                    begin
                        // Sequence complete: release the held bytes, oldest first.
                        case (held_count_reg)
                            2'd0:
                            begin
                                res_cnt      = 3'd1;
                                res_bytes[0] = b;
                            end
                            2'd1:
                            begin
                                res_cnt      = 3'd2;
                                res_bytes[0] = held_bytes_reg[7:0];
                                res_bytes[1] = b;
                            end
                            2'd2:
                            begin
                                res_cnt      = 3'd3;
                                res_bytes[0] = held_bytes_reg[15:8];
                                res_bytes[1] = held_bytes_reg[7:0];
                                res_bytes[2] = b;
                            end
                            default:
                            begin
                                res_cnt      = 3'd4;
                                res_bytes[0] = held_bytes_reg[23:16];
                                res_bytes[1] = held_bytes_reg[15:8];
                                res_bytes[2] = held_bytes_reg[7:0];
                                res_bytes[3] = b;
                            end
                        endcase
                        held_bytes_next = 24'd0;
                        held_count_next = 2'd0;
                        cont_left_next  = 2'd0;
                        mode_next       = MODE_TEXT;
                    end
                    else
                    begin
                        held_bytes_next = {held_bytes_reg[15:0], b};
                        held_count_next = held_count_reg + 2'd1;
                        cont_left_next  = cont_left_reg - 2'd1;
                    end
                end
                MODE_ESCAPE:
                begin
                    if (b == CHAR_X || b == CHAR_U)
                    begin
                        hex_unicode_next = (b == CHAR_U);
                        hex_left_next    = (b == CHAR_U) ? 3'd6 : 3'd2;
                        hex_value_next   = 24'd0;
                        mode_next        = MODE_HEX;
                    end
                    else if (!es.ok)
                    begin
                        flt      = 1'b1;
                        flt_code = ERR_BAD_ESCAPE;
                    end
                    else
                    begin
                        mode_next    = MODE_TEXT;
                        res_cnt      = 3'd1;
                        res_bytes[0] = es.value;
                    end
                end
                MODE_HEX:
                begin
                    if (!hx.ok)
                    begin
                        flt      = 1'b1;
                        flt_code = ERR_NOT_HEX;
                    end
                    else
                    begin
                        hex_value_next = nv;
                        hex_left_next  = hex_left_dec;
                        if (hex_left_dec == 3'd0)
                        begin
                            if (nv > (hex_unicode_reg ? UNICODE_MAX : HEX_BYTE_MAX))
                            begin
                                flt      = 1'b1;
                                flt_code = ERR_RANGE;
                            end
                            else if (nv >= SURR_LOW && nv <= SURR_HIGH)
                            begin
                                flt      = 1'b1;
                                flt_code = ERR_SURROGATE;
                            end
                            else
                            begin
                                hex_value_next = 24'd0;
                                mode_next      = MODE_TEXT;
                                // Re-encode the code point as UTF-8.
                                if (nv <= 24'h00007F)
                                begin
                                    res_cnt      = 3'd1;
                                    res_bytes[0] = nv[7:0];
                                end
                                else if (nv <= 24'h0007FF)
                                begin
                                    res_cnt      = 3'd2;
                                    res_bytes[0] = {3'b110, nv[10:6]};
                                    res_bytes[1] = {2'b10, nv[5:0]};
                                end
                                else if (nv <= 24'h00FFFF)
                                begin
                                    res_cnt      = 3'd3;
                                    res_bytes[0] = {4'b1110, nv[15:12]};
                                    res_bytes[1] = {2'b10, nv[11:6]};
                                    res_bytes[2] = {2'b10, nv[5:0]};
                                end
                                else
                                begin
                                    res_cnt      = 3'd4;
                                    res_bytes[0] = {5'b11110, nv[20:18]};
                                    res_bytes[1] = {2'b10, nv[17:12]};
                                    res_bytes[2] = {2'b10, nv[11:6]};
                                    res_bytes[3] = {2'b10, nv[5:0]};
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    // Idle or ended: the byte is dropped.
                end
            endcase
        end

        if (flt)
        begin
            mode_next = MODE_ENDED;
            res_cnt   = 3'd1;
            res_kind  = KIND_ERROR;
            res_code  = flt_code;
            for (int i = 0; i < 4; i++)
            begin
                res_bytes[i] = 8'd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register and decoder state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_begin_reg    <= 1'b0;
            in_byte_reg     <= 8'd0;
            mode_reg        <= MODE_IDLE;
            cont_left_reg   <= 2'd0;
            held_bytes_reg  <= 24'd0;
            held_count_reg  <= 2'd0;
            hex_value_reg   <= 24'd0;
            hex_left_reg    <= 3'd0;
            hex_unicode_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
                in_begin_reg <= s_tuser[0];
                in_byte_reg  <= s_tdata;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                mode_reg        <= mode_next;
                cont_left_reg   <= cont_left_next;
                held_bytes_reg  <= held_bytes_next;
                held_count_reg  <= held_count_next;
                hex_value_reg   <= hex_value_next;
                hex_left_reg    <= hex_left_next;
                hex_unicode_reg <= hex_unicode_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result group register, drained one result per cycle while m_tready is high
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg    <= 1'b0;
            grp_idx_reg      <= 2'd0;
            grp_last_idx_reg <= 2'd0;
        end
        else if (proc && res_cnt != 3'd0)
        begin
            grp_valid_reg    <= 1'b1;
            grp_idx_reg      <= 2'd0;
            grp_last_idx_reg <= 2'(res_cnt - 3'd1);
        end
        else if (grp_done)
        begin
            grp_valid_reg <= 1'b0;
            grp_idx_reg   <= 2'd0;
        end
        else if (out_take)
        begin
            grp_idx_reg <= grp_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && res_cnt != 3'd0)
        begin
            grp_kind_reg <= res_kind;
            grp_code_reg <= res_code;
            for (int i = 0; i < 4; i++)
            begin
                grp_bytes_reg[i] <= res_bytes[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> grp_idx_reg <= grp_last_idx_reg)
        else $error("result index ran past the end of its group");

    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg && grp_kind_reg != KIND_DATA |-> grp_last_idx_reg == 2'd0)
        else $error("done or error result is not alone in its group");

    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg && !grp_done |=> grp_valid_reg)
        else $error("result group dropped before its last result was taken");

    a_code_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[10:8] == ERR_NONE)
        else $error("fault code on a data or done result");

endmodule

// ===== bench/string_literal_unescaper_core_tb.sv =====
// ----------------------------------------------------------------------------
// String literal unescaper core testbench
// Streams literal bytes through the core and checks every result item
// against a cycle-free decoder kept in the bench. Short directed literals
// come first. Then come random literals, mostly well formed, some broken,
// under several stop byte and opening skip settings. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module string_literal_unescaper_core_tb;
    import sle_pkg::*;

    localparam int REG_STOP_BYTE    = 0;
    localparam int REG_SKIP_OPENING = 1;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int ITEMS_PER_PHASE  = 32;

    typedef enum logic [2:0] {
        LIT_IDLE,
        LIT_TEXT,
        LIT_ESCAPE,
        LIT_HEX,
        LIT_UTF8,
        LIT_ENDED
    } lit_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic [2:0] code;
        logic       fin;
    } decoded_t;

    typedef struct {
        logic       bgn;
        logic [7:0] data;
        logic       pause;
    } src_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
    logic [0:0]  s_tuser = 1'b0;   // [0] begin_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_byte, [10:8] error_code
    logic [1:0]  m_tuser;          // [1:0] kind
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Decoder state and its copy of the registers.
    logic [7:0]  stop_b = 8'd34;
    logic        skip_open = 1'b1;
    lit_mode_t   lmode = LIT_IDLE;
    logic [1:0]  cont_left = 2'd0;
    logic [23:0] held = 24'd0;
    logic [1:0]  held_n = 2'd0;
    logic [23:0] hex_val = 24'd0;
    logic [2:0]  hex_left = 3'd0;
    logic        hex_uni = 1'b0;

    decoded_t    step_q[$];
    decoded_t    decoded_q[$];
    decoded_t    want;
    src_item_t   src_q[$];
    src_item_t   cur;
    logic [7:0]  lit_q[$];
    string       esc_set = "'\"\\$0abfnrtv";

    logic        took_item = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    logic [7:0]  rx_cnt = 8'd0;
    logic [1:0]  rx_mode = 2'd0;
    int          cycle_cnt = 0;
    int          fail_cnt = 0;
    int          ph_items = 0;
    int          lit_cnt = 0;
    logic [7:0]  nstop;
    logic        nskip;

    string_literal_unescaper_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
        fail_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------
    task automatic emit(input logic [7:0] ch, input logic [1:0] kind, input logic [2:0] code);
        decoded_t r;
        r.ch   = ch;
        r.kind = kind;
        r.code = code;
        r.fin  = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic fault_to(input logic [2:0] code);
        lmode = LIT_ENDED;
        emit(8'h00, KIND_ERROR, code);
    endtask

    task automatic decode_byte(input logic bgn, input logic [7:0] b);
        logic [23:0] v;
        logic [3:0]  nib;
        logic        hex_ok;
        decoded_t    r;
        step_q.delete();
        if (bgn)
        begin
            lmode     = LIT_TEXT;
            cont_left = 2'd0;
            held      = 24'd0;
            held_n    = 2'd0;
            hex_val   = 24'd0;
            hex_left  = 3'd0;
            hex_uni   = 1'b0;
        end
        if (!(bgn && skip_open))
        begin
            case (lmode)
                LIT_TEXT:
                begin
                    if (b == stop_b)
                    begin
                        lmode = LIT_ENDED;
                        emit(8'h00, KIND_DONE, ERR_NONE);
                    end
                    else if (b == BACKSLASH)
                        lmode = LIT_ESCAPE;
                    else if (!b[7])
                        emit(b, KIND_DATA, ERR_NONE);
                    else if (b[7:6] == 2'b10)
                        fault_to(ERR_STRAY_CONT);
                    else if (b[7:3] == 5'b11111)
                        fault_to(ERR_LEAD_TOO_LONG);
                    else
                    begin
                        cont_left = !b[5] ? 2'd1 : (!b[4] ? 2'd2 : 2'd3);
                        held      = {16'd0, b};
                        held_n    = 2'd1;
                        lmode     = LIT_UTF8;
                    end
                end
                LIT_UTF8:
                begin
                    if (b[7:6] != 2'b10)
                        fault_to(ERR_MISSING_CONT);
                    else if (cont_left <= 2'd1)
                    begin
                        for (int i = 2; i >= 0; i--)
                        begin
                            if (i < held_n)
                                emit(held[8*i +: 8], KIND_DATA, ERR_NONE);
                        end
                        emit(b, KIND_DATA, ERR_NONE);
                        held      = 24'd0;
                        held_n    = 2'd0;
                        cont_left = 2'd0;
                        lmode     = LIT_TEXT;
                    end
                    else
                    begin
                        held      = {held[15:0], b};
                        held_n    = held_n + 2'd1;
                        cont_left = cont_left - 2'd1;
                    end
                end
                LIT_ESCAPE:
                begin
                    if (b == CHAR_X || b == CHAR_U)
                    begin
                        hex_uni  = (b == CHAR_U);
                        hex_left = hex_uni ? 3'd6 : 3'd2;
                        hex_val  = 24'd0;
                        lmode    = LIT_HEX;
                    end
                    else
                    begin
                        lmode = LIT_TEXT;
                        case (b)
                            "'", "\"", "\\", "$": emit(b, KIND_DATA, ERR_NONE);
                            "0": emit(8'h00, KIND_DATA, ERR_NONE);
                            "a": emit(8'h07, KIND_DATA, ERR_NONE);
                            "b": emit(8'h08, KIND_DATA, ERR_NONE);
                            "f": emit(8'h0C, KIND_DATA, ERR_NONE);
                            "n": emit(8'h0A, KIND_DATA, ERR_NONE);
                            "r": emit(8'h0D, KIND_DATA, ERR_NONE);
                            "t": emit(8'h09, KIND_DATA, ERR_NONE);
                            "v": emit(8'h0B, KIND_DATA, ERR_NONE);
                            default: fault_to(ERR_BAD_ESCAPE);
                        endcase
                    end
                end
                LIT_HEX:
                begin
                    // Digits carry their value in the low nibble; letters of both cases carry it less nine.
                    hex_ok = 1'b1;
                    nib    = 4'd0;
                    if (b >= "0" && b <= "9")
                        nib = b[3:0];
                    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
                        nib = b[3:0] + 4'd9;
                    else
                        hex_ok = 1'b0;
                    if (!hex_ok)
                        fault_to(ERR_NOT_HEX);
                    else
                    begin
                        hex_val  = {hex_val[19:0], nib};
                        hex_left = hex_left - 3'd1;
                        if (hex_left == 3'd0)
                        begin
                            v = hex_val;
                            if (v > (hex_uni ? UNICODE_MAX : HEX_BYTE_MAX))
                                fault_to(ERR_RANGE);
                            else if (v >= SURR_LOW && v <= SURR_HIGH)
                                fault_to(ERR_SURROGATE);
                            else
                            begin
                                hex_val = 24'd0;
                                lmode   = LIT_TEXT;
                                if (v <= 24'h7F)
                                    emit(v[7:0], KIND_DATA, ERR_NONE);
                                else if (v <= 24'h7FF)
                                begin
                                    emit({3'b110, v[10:6]}, KIND_DATA, ERR_NONE);
                                    emit({2'b10, v[5:0]}, KIND_DATA, ERR_NONE);
                                end
                                else if (v <= 24'hFFFF)
                                begin
                                    emit({4'b1110, v[15:12]}, KIND_DATA, ERR_NONE);
                                    emit({2'b10, v[11:6]}, KIND_DATA, ERR_NONE);
                                    emit({2'b10, v[5:0]}, KIND_DATA, ERR_NONE);
                                end
                                else
                                begin
                                    emit({5'b11110, v[20:18]}, KIND_DATA, ERR_NONE);
                                    emit({2'b10, v[17:12]}, KIND_DATA, ERR_NONE);
                                    emit({2'b10, v[11:6]}, KIND_DATA, ERR_NONE);
                                    emit({2'b10, v[5:0]}, KIND_DATA, ERR_NONE);
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        for (int i = 0; i < step_q.size(); i++)
        begin
            r     = step_q[i];
            r.fin = (i == step_q.size() - 1);
            decoded_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: input acceptance feeds the decoder, results are checked.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        took_item <= rst_n && s_tvalid && s_tready;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                          m_tdata[7:0], m_tuser));
            else
            begin
                want = decoded_q.pop_front();
                if (m_tdata[7:0] != want.ch)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_tdata[7:0], want.ch));
                if (m_tuser != want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[10:8] != want.code)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              m_tdata[10:8], want.code));
                if (m_tlast != want.fin)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.fin));
            end
        end
        if (rst_n && s_tvalid && s_tready)
            decode_byte(s_tuser[0], s_tdata);
    end

    always @(posedge clk)
    begin
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps between them.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || took_item))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (src_q.size() != 0 && (!src_q[0].pause || decoded_q.size() == 0))
            begin
                cur = src_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur.data;
                s_tuser  <= cur.bgn;
                if (burst_left == 0)
                begin
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                              : $urandom_range(1, 8);
                    gap_left   <= $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver readiness follows a mode that is drawn anew whenever rx_cnt[6:0] is zero.
    always @(negedge clk)
    begin
        rx_cnt <= rx_cnt + 8'd1;
        if (rx_cnt[6:0] == 7'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_cnt[2:0] < 3'd5);
            default: m_tready <= (rx_cnt[4:0] >= 5'd8);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic bgn, input logic [7:0] b, input logic pause);
        src_item_t it;
        it.bgn   = bgn;
        it.data  = b;
        it.pause = pause;
        src_q.push_back(it);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'("0" + nib);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 4'd10);
    endfunction

    task automatic push_hex(input logic [23:0] v, input int ndig);
        for (int i = ndig - 1; i >= 0; i--)
            lit_q.push_back(hex_char(v[4*i +: 4]));
    endtask

    // Lead byte of a k-byte UTF-8 sequence followed by ncont continuation bytes.
    task automatic push_utf8(input int k, input int ncont);
        logic [7:0] c;
        c = 8'($urandom);
        case (k)
            2: lit_q.push_back({3'b110, c[4:0]});
            3: lit_q.push_back({4'b1110, c[3:0]});
            default: lit_q.push_back({5'b11110, c[2:0]});
        endcase
        repeat (ncont)
        begin
            c = 8'($urandom);
            lit_q.push_back({2'b10, c[5:0]});
        end
    endtask

    task automatic push_escape(input logic [7:0] c);
        lit_q.push_back(BACKSLASH);
        lit_q.push_back(c);
    endtask

    task automatic gen_literal();
        int          k;
        logic [23:0] v;
        logic [7:0]  c;
        lit_q.delete();
        if (skip_open)
            lit_q.push_back(($urandom_range(0, 3) != 0) ? stop_b : 8'($urandom));
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 6))
                0, 1:
                begin
                    c = 8'($urandom_range(0, 127));
                    lit_q.push_back((c == BACKSLASH) ? "z" : c);
                end
                2:
                begin
                    k = $urandom_range(2, 4);
                    push_utf8(k, k - 1);
                end
                3: push_escape(esc_set[$urandom_range(0, 11)]);
                4:
                begin
                    push_escape(CHAR_X);
                    push_hex(24'($urandom_range(0, 127)), 2);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 24'($urandom_range(0, 'h7F));
                        1: v = 24'($urandom_range('h80, 'h7FF));
                        2:
                        begin
                            v = 24'($urandom_range('h800, 'hFFFF));
                            if (v >= SURR_LOW && v <= SURR_HIGH)
                                v = v ^ 24'h4000;
                        end
                        default: v = 24'($urandom_range('h10000, 'h10FFFF));
                    endcase
                    push_escape(CHAR_U);
                    push_hex(v, 6);
                end
            endcase
        end
        c = 8'($urandom);
        case ($urandom_range(0, 15))
            9: lit_q.push_back({2'b10, c[5:0]});
            10: lit_q.push_back({5'b11111, c[2:0]});
            11:
            begin
                k = $urandom_range(2, 4);
                push_utf8(k, $urandom_range(0, k - 2));
                c = 8'($urandom);
                if (c[7:6] == 2'b10)
                    c[6] = 1'b1;
                lit_q.push_back(c);
            end
            12: push_escape(c);
            13:
            begin
                push_escape($urandom_range(0, 1) ? CHAR_U : CHAR_X);
                push_hex(24'($urandom), $urandom_range(0, 1));
                c = 8'($urandom);
                lit_q.push_back((c[7:6] == 2'b00 && c[5:4] == 2'b11) ? "g" : c);
            end
            14:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_escape(CHAR_X);
                        push_hex(24'($urandom_range(128, 255)), 2);
                    end
                    1:
                    begin
                        push_escape(CHAR_U);
                        push_hex(24'($urandom_range('h110000, 'hFFFFFF)), 6);
                    end
                    default:
                    begin
                        push_escape(CHAR_U);
                        push_hex(24'($urandom_range('hD800, 'hDFFF)), 6);
                    end
                endcase
            end
            15:
            begin
                // Left open: the next begin abandons it.
            end
            default: lit_q.push_back(stop_b);
        endcase
        if (lit_q.size() == 0)
            lit_q.push_back(stop_b);
        foreach (lit_q[i])
            push_item(i == 0, lit_q[i], i == 0 && lit_cnt % 6 == 5);
        ph_items += lit_q.size();
        lit_cnt++;
        // Bytes after the literal has ended are ignored by the core; after one left open they are decoded.
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                push_item(1'b0, 8'($urandom), 1'b0);
        end
    endtask

    task automatic wait_idle();
        while (src_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] val);
        logic [31:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(idx * 4);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_STOP_BYTE)
            stop_b = val[7:0];
        else
            skip_open = val[0];
        readback = (idx == REG_STOP_BYTE) ? {24'd0, val[7:0]} : {31'd0, val[0]};
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata != readback)
            report_mismatch($sformatf("register %0d reads %08h, want %08h",
                                      idx, prdata, readback));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        // Directed literals under the reset settings: stop on '"', skip opening.
        push_item(1'b0, "A", 1'b0);          // no begin yet
        push_item(1'b1, "\"", 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h7F, 1'b0);
        push_item(1'b0, 8'hC3, 1'b0);        // two-byte UTF-8
        push_item(1'b0, 8'hA9, 1'b0);
        push_item(1'b0, BACKSLASH, 1'b0);    // largest code point, four bytes out
        push_item(1'b0, CHAR_U, 1'b0);
        push_item(1'b0, "1", 1'b0);
        push_item(1'b0, "0", 1'b0);
        push_item(1'b0, "F", 1'b0);
        push_item(1'b0, "f", 1'b0);
        push_item(1'b0, "F", 1'b0);
        push_item(1'b0, "f", 1'b0);
        push_item(1'b0, BACKSLASH, 1'b0);    // stop byte inside an escape
        push_item(1'b0, "\"", 1'b0);
        push_item(1'b0, "\"", 1'b0);
        push_item(1'b0, 8'hFF, 1'b0);        // ignored after done
        push_item(1'b1, "\"", 1'b1);
        push_item(1'b0, 8'h80, 1'b0);        // stray continuation
        push_item(1'b1, "\"", 1'b0);
        push_item(1'b0, 8'hF8, 1'b0);        // lead too long
        push_item(1'b1, "\"", 1'b0);
        push_item(1'b0, BACKSLASH, 1'b0);
        push_item(1'b0, "q", 1'b0);          // unknown escape

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin nstop = 8'h00; nskip = 1'b0; end
                1: begin nstop = 8'hFF; nskip = 1'b1; end
                2: begin nstop = "'";   nskip = 1'b0; end
                3: begin nstop = 8'($urandom); nskip = 1'b1; end
                default: begin nstop = "\""; nskip = 1'($urandom_range(0, 1)); end
            endcase
            write_reg(REG_STOP_BYTE, {24'd0, nstop});
            write_reg(REG_SKIP_OPENING, {31'd0, nskip});
            ph_items = 0;
            while (ph_items < ITEMS_PER_PHASE)
                gen_literal();
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
